/* rtl/core/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/core/elt_pkg.sv */
`timescale 1ns / 1ps

package elt_pkg;

    // table size
    localparam int NUM_SLOTS = 64;
    localparam int NUM_HARTS = 8;

    // fixed field widths
    localparam int SID_W = 6;
    localparam int HID_W = 3;
    localparam int TOK_W = 64;

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int HART_W = (NUM_HARTS > 1) ? $clog2(NUM_HARTS) : 1;
    localparam int SID_EXT_W = (SLOT_W > SID_W) ? SLOT_W : SID_W;
    localparam int HID_EXT_W = (HART_W > HID_W) ? HART_W : HID_W;

    // free-slot scan: eight slots looked at per cycle
    localparam int SCAN_LANES = 8;
    localparam int LANE_W = $clog2(SCAN_LANES);
    localparam int NUM_CHUNKS = (NUM_SLOTS + SCAN_LANES - 1) / SCAN_LANES;
    localparam int CHUNK_W = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
    localparam int PAD_W = NUM_CHUNKS * SCAN_LANES;
    localparam int FOUND_W = CHUNK_W + LANE_W;

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [HART_W-1:0] t_hart;

    typedef enum logic [3:0] {
        CMD_CREATE         = 4'd0,
        CMD_RUN            = 4'd1,
        CMD_STOP           = 4'd2,
        CMD_DESTROY        = 4'd3,
        CMD_RESUME_STOPPED = 4'd4,
        CMD_RESUME         = 4'd5,
        CMD_EXIT           = 4'd6,
        CMD_OUTCALL        = 4'd7,
        CMD_TIMER_TICK     = 4'd8
    } t_cmd;

    typedef enum logic [2:0] {
        ST_INVALID   = 3'd0,
        ST_FRESH     = 3'd1,
        ST_RUNNABLE  = 3'd2,
        ST_RUNNING   = 3'd3,
        ST_STOPPED   = 3'd4,
        ST_DESTROYED = 3'd5
    } t_slot_st;

    typedef enum logic [2:0] {
        RS_OK    = 3'd0,
        RS_ERR   = 3'd1,
        RS_TIMER = 3'd2,
        RS_OCALL = 3'd3,
        RS_DONE  = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_SCAN,
        SEQ_READ,
        SEQ_EXEC,
        SEQ_RESP
    } t_seq;

    // result of the free-slot scan
    typedef struct packed {
        logic  done;
        logic  found;
        t_slot slot;
    } t_scan_res;

endpackage

/* rtl/core/elt_free_scan.sv */
`timescale 1ns / 1ps

module elt_free_scan (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [elt_pkg::NUM_SLOTS-1:0] i_used,
    output elt_pkg::t_scan_res            o_res
);
    import elt_pkg::*;

    logic                 r_run;
    logic                 r_done;
    logic                 r_found;
    t_slot                r_slot;
    logic [CHUNK_W-1:0]   r_chunk;
    logic [PAD_W-1:0]     free_pad;
    logic [SCAN_LANES-1:0] chunk;
    logic                 hit;
    logic [LANE_W-1:0]    lane;
    logic [FOUND_W-1:0]   idx;
    logic                 last;

    // pad the free map with busy entries up to whole chunks
    assign free_pad = PAD_W'(~i_used);
    assign chunk    = free_pad[{r_chunk, LANE_W'(0)} +: SCAN_LANES];
    assign last     = (r_chunk == CHUNK_W'(NUM_CHUNKS - 1));

    // lowest free lane of the current chunk
    always_comb begin
        hit  = 1'b0;
        lane = '0;
        for (int i = SCAN_LANES - 1; i >= 0; i--) begin
            if (chunk[i]) begin
                hit  = 1'b1;
                lane = LANE_W'(i);
            end
        end
    end

    assign idx = {r_chunk, lane};

    // control: run until a free slot or the last chunk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_run  <= 1'b1;
            r_done <= 1'b0;
        end else if (r_run && (hit || last)) begin
            r_run  <= 1'b0;
            r_done <= 1'b1;
        end else begin
            r_done <= 1'b0;
        end
    end

    // advance the chunk counter and hold the result
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_chunk <= '0;
        end else if (r_run) begin
            if (hit || last) begin
                r_found <= hit;
                r_slot  <= idx[SLOT_W-1:0];
            end else begin
                r_chunk <= r_chunk + CHUNK_W'(1);
            end
        end
    end

    assign o_res.done  = r_done;
    assign o_res.found = r_found;
    assign o_res.slot  = r_slot;

endmodule

/* rtl/core/enclave_lifecycle_table.sv */
`timescale 1ns / 1ps

// Lifecycle table for NUM_SLOTS execution slots and NUM_HARTS harts. A command
// is taken when start is high and busy is low; its result is marked on the
// o_ ports by o_done, high for exactly one cycle, and must be taken then:
// the receiver cannot hold it off. Every command other than create passes
// through the read, execute and response states, and the next command can
// be taken once the block is back in idle after the response. The slot table
// is a single-port memory read at most once and written at most once per
// command; create does not read it but runs a free-slot scan that looks at
// eight slots a cycle. There is no clearing pass after reset.
module enclave_lifecycle_table (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [3:0]                  i_cmd,
    input  logic [elt_pkg::SID_W-1:0]   i_slot_id,
    input  logic [elt_pkg::HID_W-1:0]   i_hart_id,
    input  logic [elt_pkg::TOK_W-1:0]   i_owner_token,
    input  logic                        i_create_checks_ok,
    input  logic                        i_grant_ok,
    input  logic                        i_platform_ok,
    output logic                        o_done,
    output logic [2:0]                  o_status,
    output logic [elt_pkg::SID_W-1:0]   o_new_slot,
    output logic                        o_enter_world,
    output logic                        o_leave_world,
    output logic                        o_release_memory
);
    import elt_pkg::*;

    // sequencer
    t_seq r_seq;
    t_seq n_seq;

    // per-slot in-use bits (an unused slot reads as invalid)
    logic [NUM_SLOTS-1:0] r_used;
    // slot table memories
    t_slot_st             r_state_mem [NUM_SLOTS];
    logic [TOK_W-1:0]     r_owner_mem [NUM_SLOTS];
    // per-hart records
    logic [NUM_HARTS-1:0] r_hart_active;
    t_slot                r_hart_slot [NUM_HARTS];

    // captured transaction
    logic [3:0]           r_cmd;
    t_slot                r_sid;
    t_slot                r_addr;
    t_hart                r_hid;
    logic [TOK_W-1:0]     r_tok;
    logic                 r_cre_ok;
    logic                 r_grant;
    logic                 r_plat;
    logic                 r_slot_ok;
    logic                 r_hart_ok;

    // memory read data
    t_slot_st             r_rd_state;
    logic [TOK_W-1:0]     r_rd_owner;

    // result registers
    t_status              r_status;
    logic [SID_W-1:0]     r_new_slot;
    logic                 r_enter;
    logic                 r_leave;
    logic                 r_rel;

    // control
    logic                 accept;
    logic                 scan_start;
    logic                 rd_en;
    logic                 exec_en;
    t_scan_res            scan_res;

    // input conversion
    logic [SID_EXT_W-1:0] sid_ext;
    logic [HID_EXT_W-1:0] hid_ext;
    t_slot                sid_idx;
    t_hart                hid_idx;
    logic                 in_hart_cmd;

    // decision
    t_slot_st             cur_st;
    logic                 owns;
    logic                 hart_act;
    t_status              d_status;
    logic                 d_enter;
    logic                 d_leave;
    logic                 d_rel;
    logic                 d_wr;
    logic                 d_free;
    t_slot_st             d_new_st;
    logic                 d_own_we;
    logic                 d_hart_set;
    logic                 d_hart_clr;
    logic                 d_new_ok;
    t_slot                wr_addr;
    logic [SID_EXT_W-1:0] found_ext;

    // free-slot scanner
    elt_free_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (scan_start),
        .i_used  (r_used),
        .o_res   (scan_res)
    );

    // sequencer: next state
    always_comb begin
        n_seq = r_seq;
        unique case (r_seq)
            SEQ_IDLE: begin
                if (start) begin
                    n_seq = (i_cmd == CMD_CREATE) ? SEQ_SCAN : SEQ_READ;
                end
            end
            SEQ_SCAN: begin
                if (scan_res.done) begin
                    n_seq = SEQ_EXEC;
                end
            end
            SEQ_READ: n_seq = SEQ_EXEC;
            SEQ_EXEC: n_seq = SEQ_RESP;
            SEQ_RESP: n_seq = SEQ_IDLE;
            default:  n_seq = SEQ_IDLE;
        endcase
    end

    // sequencer: outputs
    always_comb begin
        busy       = 1'b1;
        o_done     = 1'b0;
        accept     = 1'b0;
        scan_start = 1'b0;
        rd_en      = 1'b0;
        exec_en    = 1'b0;
        unique case (r_seq)
            SEQ_IDLE: begin
                busy       = 1'b0;
                accept     = start;
                scan_start = start && (i_cmd == CMD_CREATE);
            end
            SEQ_SCAN: ;
            SEQ_READ: rd_en = 1'b1;
            SEQ_EXEC: exec_en = 1'b1;
            SEQ_RESP: o_done = 1'b1;
            default:  ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq <= SEQ_IDLE;
        end else begin
            r_seq <= n_seq;
        end
    end

    // convert the incoming indexes to table widths
    assign sid_ext     = SID_EXT_W'(i_slot_id);
    assign hid_ext     = HID_EXT_W'(i_hart_id);
    assign sid_idx     = sid_ext[SLOT_W-1:0];
    assign hid_idx     = hid_ext[HART_W-1:0];
    assign in_hart_cmd = (i_cmd == CMD_EXIT) || (i_cmd == CMD_OUTCALL) ||
                         (i_cmd == CMD_TIMER_TICK);

    // capture the transaction; hart commands address the hart's slot
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd     <= i_cmd;
            r_sid     <= sid_idx;
            r_addr    <= in_hart_cmd ? r_hart_slot[hid_idx] : sid_idx;
            r_hid     <= hid_idx;
            r_tok     <= i_owner_token;
            r_cre_ok  <= i_create_checks_ok;
            r_grant   <= i_grant_ok;
            r_plat    <= i_platform_ok;
            r_slot_ok <= (int'(i_slot_id) < NUM_SLOTS);
            r_hart_ok <= (int'(i_hart_id) < NUM_HARTS);
        end
    end

    // read the slot entry
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_state <= r_state_mem[r_addr];
            r_rd_owner <= r_owner_mem[r_addr];
        end
    end

    assign cur_st   = r_used[r_addr] ? r_rd_state : ST_INVALID;
    assign owns     = r_slot_ok && (r_rd_owner == r_tok);
    assign hart_act = r_hart_ok && r_hart_active[r_hid];

    // decide the transition and the result
    always_comb begin
        d_status   = RS_ERR;
        d_enter    = 1'b0;
        d_leave    = 1'b0;
        d_rel      = 1'b0;
        d_wr       = 1'b0;
        d_free     = 1'b0;
        d_new_st   = ST_INVALID;
        d_own_we   = 1'b0;
        d_hart_set = 1'b0;
        d_hart_clr = 1'b0;
        d_new_ok   = 1'b0;
        unique case (r_cmd) inside
            CMD_CREATE: begin
                if (scan_res.found && r_cre_ok) begin
                    d_wr     = 1'b1;
                    d_new_st = ST_FRESH;
                    d_own_we = 1'b1;
                    d_new_ok = 1'b1;
                    d_status = RS_OK;
                end else begin
                    d_rel = 1'b1;
                end
            end
            CMD_RUN: begin
                if (owns && (cur_st == ST_FRESH) && r_grant && r_hart_ok) begin
                    d_wr       = 1'b1;
                    d_new_st   = ST_RUNNING;
                    d_hart_set = 1'b1;
                    d_enter    = 1'b1;
                    d_status   = RS_OK;
                end
            end
            CMD_STOP: begin
                if (owns && ((cur_st == ST_RUNNABLE) || (cur_st == ST_RUNNING))) begin
                    d_wr     = 1'b1;
                    d_new_st = ST_STOPPED;
                    d_status = RS_OK;
                end
            end
            CMD_DESTROY: begin
                if (owns && (cur_st == ST_FRESH)) begin
                    d_wr     = 1'b1;
                    d_free   = 1'b1;
                    d_rel    = 1'b1;
                    d_status = RS_OK;
                end else if (owns && ((cur_st == ST_RUNNABLE) ||
                                      (cur_st == ST_RUNNING) ||
                                      (cur_st == ST_STOPPED))) begin
                    d_wr     = 1'b1;
                    d_new_st = ST_DESTROYED;
                    d_status = RS_OK;
                end
            end
            CMD_RESUME_STOPPED: begin
                if (owns && (cur_st == ST_STOPPED)) begin
                    d_wr     = 1'b1;
                    d_new_st = ST_RUNNABLE;
                    d_status = RS_OK;
                end
            end
            CMD_RESUME: begin
                if (owns) begin
                    if (cur_st == ST_STOPPED) begin
                        d_status = RS_TIMER;
                    end else if (cur_st == ST_DESTROYED) begin
                        d_wr     = 1'b1;
                        d_free   = 1'b1;
                        d_rel    = 1'b1;
                        d_status = RS_DONE;
                    end else if ((cur_st == ST_RUNNABLE) && r_grant && r_hart_ok) begin
                        d_wr       = 1'b1;
                        d_new_st   = ST_RUNNING;
                        d_hart_set = 1'b1;
                        d_enter    = 1'b1;
                        d_status   = RS_OK;
                    end
                end
            end
            CMD_EXIT, CMD_OUTCALL: begin
                if (hart_act && r_plat && (cur_st == ST_RUNNING)) begin
                    d_hart_clr = 1'b1;
                    d_leave    = 1'b1;
                    d_wr       = 1'b1;
                    if (r_cmd == CMD_EXIT) begin
                        d_free   = 1'b1;
                        d_rel    = 1'b1;
                        d_status = RS_OK;
                    end else begin
                        d_new_st = ST_RUNNABLE;
                        d_status = RS_OCALL;
                    end
                end
            end
            CMD_TIMER_TICK: begin
                if (hart_act) begin
                    d_hart_clr = 1'b1;
                    d_leave    = 1'b1;
                    d_status   = RS_TIMER;
                    if (cur_st == ST_DESTROYED) begin
                        d_wr     = 1'b1;
                        d_free   = 1'b1;
                        d_rel    = 1'b1;
                        d_status = RS_DONE;
                    end else if (cur_st == ST_RUNNING) begin
                        d_wr     = 1'b1;
                        d_new_st = ST_RUNNABLE;
                    end
                end
            end
            default: ;
        endcase
    end

    assign wr_addr   = (r_cmd == CMD_CREATE) ? scan_res.slot : r_addr;
    assign found_ext = SID_EXT_W'(scan_res.slot);

    // update in-use bits and hart activity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used        <= '0;
            r_hart_active <= '0;
        end else if (exec_en) begin
            if (d_wr) begin
                r_used[wr_addr] <= !d_free;
            end
            if (d_hart_set) begin
                r_hart_active[r_hid] <= 1'b1;
            end else if (d_hart_clr) begin
                r_hart_active[r_hid] <= 1'b0;
            end
        end
    end

    // write the slot memories and the hart's slot record
    always_ff @(posedge i_clk) begin
        if (exec_en) begin
            if (d_wr && !d_free) begin
                r_state_mem[wr_addr] <= d_new_st;
            end
            if (d_own_we) begin
                r_owner_mem[wr_addr] <= r_tok;
            end
            if (d_hart_set) begin
                r_hart_slot[r_hid] <= r_sid;
            end
        end
    end

    // hold the result for the strobe cycle
    always_ff @(posedge i_clk) begin
        if (exec_en) begin
            r_status   <= d_status;
            r_new_slot <= d_new_ok ? found_ext[SID_W-1:0] : '0;
            r_enter    <= d_enter;
            r_leave    <= d_leave;
            r_rel      <= d_rel;
        end
    end

    assign o_status         = r_status;
    assign o_new_slot       = r_new_slot;
    assign o_enter_world    = r_enter;
    assign o_leave_world    = r_leave;
    assign o_release_memory = r_rel;

endmodule

/* rtl/core/elt_checker.sv */
`timescale 1ns / 1ps

`include "assert_macros.svh"

module elt_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      start,
    input logic                      busy,
    input logic                      o_done,
    input logic [2:0]                o_status,
    input logic [elt_pkg::SID_W-1:0] o_new_slot,
    input logic                      o_enter_world,
    input logic                      o_leave_world,
    input logic                      o_release_memory
);
    import elt_pkg::*;

    // an accepted transaction keeps the block busy
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)

    // the result strobe lasts one cycle
    `ASSERT_NEXT(a_done_pulse, i_clk, i_rst_n, o_done, !o_done)

    // entering a slot is a plain success with nothing else signalled
    `ASSERT_IMPL(a_enter_ok, i_clk, i_rst_n, o_done && o_enter_world, (o_status == RS_OK) && !o_leave_world && !o_release_memory)

    // a slot number is only handed back by a successful create
    `ASSERT_IMPL(a_new_slot_ok, i_clk, i_rst_n, o_done && (o_new_slot != '0), (o_status == RS_OK) && !o_release_memory && !o_leave_world)

endmodule

bind enclave_lifecycle_table elt_checker u_elt_checker (.*);
